[hw/rtl/poc_pkg.sv]
// ----------------------------------------------------------------------------
// poc_pkg: shared types and constants of the pointer overlay compositor
// Request/response payloads, config register codes, stage structs.
// ----------------------------------------------------------------------------
package poc_pkg;

  localparam int unsigned XY_W       = 12;
  localparam int unsigned CH_W       = 8;
  localparam int unsigned TEXEL_W    = 32;
  localparam int unsigned SHAPE_W    = 6;
  localparam int unsigned POS_W      = 13;
  localparam int unsigned SIZE_W     = 7;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;
  // pixel coordinate minus pointer origin, signed
  localparam int unsigned DELTA_W    = 15;

  localparam logic [15:0]     ROUND_HALF = 16'd127;
  localparam logic [CH_W-1:0] CH_MAX     = 8'hFF;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_PIXEL = 1'b1;

  typedef enum logic [1:0] {
    MODE_ALPHA  = 2'd0,
    MODE_MASKED = 2'd1,
    MODE_MONO   = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE   = 3'd0,
    CFG_POS_X  = 3'd1,
    CFG_POS_Y  = 3'd2,
    CFG_WIDTH  = 3'd3,
    CFG_HEIGHT = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic                req_type;
    logic [XY_W-1:0]     pixel_x;
    logic [XY_W-1:0]     pixel_y;
    logic [CH_W-1:0]     dest_blue;
    logic [CH_W-1:0]     dest_green;
    logic [CH_W-1:0]     dest_red;
    logic [CH_W-1:0]     dest_alpha;
    logic [SHAPE_W-1:0]  shape_row;
    logic [SHAPE_W-1:0]  shape_col;
    logic [TEXEL_W-1:0]  shape_texel;
  } in_req_t;

  typedef struct packed {
    logic [CH_W-1:0] out_blue;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_alpha;
    logic            inside_pointer;
    logic            shape_error;
  } out_rsp_t;

  typedef struct packed {
    mode_e                    mode;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic [SIZE_W-1:0]        width;
    logic [SIZE_W-1:0]        height;
  } cfg_t;

  // per-stage load enables and stage 1 occupancy
  typedef struct packed {
    logic accept;
    logic s1_en;
    logic s2_en;
    logic s3_en;
    logic out_en;
    logic s1_vld;
  } pipe_ctl_t;

  typedef struct packed {
    logic [CH_W-1:0] b;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] a;
  } px_t;

  // side info that travels alongside the shape store read
  typedef struct packed {
    logic is_pixel;
    logic in_rect;
    logic err;
    px_t  dest;
  } s2_t;

endpackage

[hw/rtl/poc_ram.sv]
// ----------------------------------------------------------------------------
// poc_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module poc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/poc_locate.sv]
// ----------------------------------------------------------------------------
// poc_locate: front stages of the compositor
// Error flag, pointer-relative offsets, hit test and shape store addressing.
// ----------------------------------------------------------------------------
module poc_locate
  import poc_pkg::*;
#(
  parameter int unsigned MAX_POINTER_SIZE = 64,
  parameter int unsigned COORD_BITS       = 12,
  localparam int unsigned AddrW = $clog2(MAX_POINTER_SIZE * MAX_POINTER_SIZE)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pipe_ctl_t           ctl_i,
  input  in_req_t             req_i,
  input  cfg_t                cfg_i,
  output logic                ram_we_o,
  output logic [AddrW-1:0]    ram_waddr_o,
  output logic [TEXEL_W-1:0]  ram_wdata_o,
  output logic                ram_re_o,
  output logic [AddrW-1:0]    ram_raddr_o,
  output s2_t                 s2_o
);

  localparam int unsigned IdxW = $clog2(MAX_POINTER_SIZE);
  localparam int unsigned MagW = DELTA_W - 1;
  localparam logic [XY_W-1:0] CoordMask = XY_W'((64'(1) << COORD_BITS) - 64'(1));

  typedef struct packed {
    logic                       is_pixel;
    logic                       err;
    logic signed [DELTA_W-1:0]  dx;
    logic signed [DELTA_W-1:0]  dy;
    logic [SHAPE_W-1:0]         row_idx;
    logic [SHAPE_W-1:0]         col_idx;
    logic [TEXEL_W-1:0]         texel;
    px_t                        dest;
  } s1_t;

  // load row/col wrapped into the store; few steps on a 6-bit value
  function automatic logic [SHAPE_W-1:0] wrap_idx(input logic [SHAPE_W-1:0] v);
    logic [SHAPE_W-1:0] r;
    r = v;
    for (int i = 0; i < 8; i++) begin
      if (int'(r) >= int'(MAX_POINTER_SIZE)) begin
        r = r - SHAPE_W'(MAX_POINTER_SIZE);
      end
    end
    return r;
  endfunction

  logic                flag_q, flag_d;
  s1_t                 s1_q, s1_d;
  s2_t                 s2_q, s2_d;
  logic [XY_W-1:0]     px_m, py_m;
  logic [CH_W-1:0]     load_alpha;
  logic                load_in_rect;
  logic [MagW-1:0]     dx_mag, dy_mag;
  logic                mode_ok;
  logic                hit;

  // error flag: updated as the request is accepted
  assign load_alpha   = req_i.shape_texel[TEXEL_W-1 -: CH_W];
  assign load_in_rect = ({1'b0, req_i.shape_col} < cfg_i.width) &&
                        (int'(req_i.shape_col) < int'(MAX_POINTER_SIZE)) &&
                        ({1'b0, req_i.shape_row} < cfg_i.height) &&
                        (int'(req_i.shape_row) < int'(MAX_POINTER_SIZE));

  always_comb begin
    flag_d = flag_q;
    if (req_i.req_type == REQ_LOAD) begin
      if (req_i.shape_row == '0 && req_i.shape_col == '0) begin
        flag_d = 1'b0;
      end
      if (cfg_i.mode == MODE_MASKED && load_in_rect &&
          load_alpha != '0 && load_alpha != CH_MAX) begin
        flag_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= 1'b0;
    end else if (ctl_i.accept) begin
      flag_q <= flag_d;
    end
  end

  // stage 1: offsets from the pointer origin
  assign px_m = req_i.pixel_x & CoordMask;
  assign py_m = req_i.pixel_y & CoordMask;

  always_comb begin
    s1_d.is_pixel = (req_i.req_type == REQ_PIXEL);
    s1_d.err      = flag_d;
    s1_d.dx       = $signed({3'b000, px_m}) - $signed({{2{cfg_i.pos_x[POS_W-1]}}, cfg_i.pos_x});
    s1_d.dy       = $signed({3'b000, py_m}) - $signed({{2{cfg_i.pos_y[POS_W-1]}}, cfg_i.pos_y});
    s1_d.row_idx  = wrap_idx(req_i.shape_row);
    s1_d.col_idx  = wrap_idx(req_i.shape_col);
    s1_d.texel    = req_i.shape_texel;
    s1_d.dest     = '{b: req_i.dest_blue, g: req_i.dest_green,
                      r: req_i.dest_red,  a: req_i.dest_alpha};
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.s1_en) begin
      s1_q <= s1_d;
    end
  end

  // stage 2: hit test, store access
  assign dx_mag  = s1_q.dx[MagW-1:0];
  assign dy_mag  = s1_q.dy[MagW-1:0];
  assign mode_ok = (cfg_i.mode == MODE_ALPHA) || (cfg_i.mode == MODE_MASKED) ||
                   (cfg_i.mode == MODE_MONO);
  assign hit = s1_q.is_pixel && !s1_q.err && mode_ok &&
               !s1_q.dx[DELTA_W-1] && !s1_q.dy[DELTA_W-1] &&
               (dx_mag < MagW'(cfg_i.width))  && (dx_mag < MagW'(MAX_POINTER_SIZE)) &&
               (dy_mag < MagW'(cfg_i.height)) && (dy_mag < MagW'(MAX_POINTER_SIZE));

  assign ram_we_o    = ctl_i.s2_en && ctl_i.s1_vld && !s1_q.is_pixel;
  assign ram_waddr_o = AddrW'(s1_q.row_idx) * AddrW'(MAX_POINTER_SIZE) +
                       AddrW'(s1_q.col_idx);
  assign ram_wdata_o = s1_q.texel;
  assign ram_re_o    = ctl_i.s2_en && ctl_i.s1_vld && hit;
  assign ram_raddr_o = AddrW'(dy_mag[IdxW-1:0]) * AddrW'(MAX_POINTER_SIZE) +
                       AddrW'(dx_mag[IdxW-1:0]);

  always_comb begin
    s2_d.is_pixel = s1_q.is_pixel;
    s2_d.in_rect  = hit;
    s2_d.err      = s1_q.err;
    s2_d.dest     = s1_q.dest;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.s2_en) begin
      s2_q <= s2_d;
    end
  end

  assign s2_o = s2_q;

endmodule

[hw/rtl/poc_compose.sv]
// ----------------------------------------------------------------------------
// poc_compose: back stages of the compositor
// Blend products, masked/monochrome ops, divide by 255 and output register.
// ----------------------------------------------------------------------------
module poc_compose
  import poc_pkg::*;
(
  input  logic                clk_i,
  input  pipe_ctl_t           ctl_i,
  input  mode_e               mode_i,
  input  s2_t                 s2_i,
  input  logic [TEXEL_W-1:0]  texel_i,
  output out_rsp_t            rsp_o
);

  typedef struct packed {
    logic            is_pixel;
    logic            in_rect;
    logic            err;
    logic            use_mix;
    logic [CH_W-1:0] alpha;
    logic [15:0]     sum_b;
    logic [15:0]     sum_g;
    logic [15:0]     sum_r;
    logic [CH_W-1:0] alt_b;
    logic [CH_W-1:0] alt_g;
    logic [CH_W-1:0] alt_r;
  } s3_t;

  // s*a + d*(255-a) + 127, at most 65152
  function automatic logic [15:0] mix_sum(input logic [CH_W-1:0] s,
                                          input logic [CH_W-1:0] d,
                                          input logic [CH_W-1:0] a);
    return 16'(s) * 16'(a) + 16'(d) * 16'(CH_MAX - a) + ROUND_HALF;
  endfunction

  // exact v/255 for v below 65280
  function automatic logic [CH_W-1:0] div255(input logic [15:0] v);
    logic [16:0] t;
    t = 17'(v) + 17'(1) + 17'(v[15:8]);
    return t[15:8];
  endfunction

  function automatic logic [CH_W-1:0] alt_ch(input mode_e m,
                                             input logic in_rect,
                                             input logic is_pixel,
                                             input logic [CH_W-1:0] s,
                                             input logic [CH_W-1:0] d,
                                             input logic [TEXEL_W-1:0] t);
    logic [CH_W-1:0] r;
    r = d;
    if (!is_pixel) begin
      r = '0;
    end else if (in_rect) begin
      case (m)
        MODE_MASKED: r = (t[TEXEL_W-1 -: CH_W] == '0) ? s : (d ^ s);
        MODE_MONO:   r = (d & {CH_W{t[0]}}) ^ {CH_W{t[1]}};
        default:     r = d;
      endcase
    end
    return r;
  endfunction

  s3_t              s3_q, s3_d;
  out_rsp_t         rsp_q, rsp_d;
  logic [CH_W-1:0]  ta, tb, tg, tr;

  assign tb = texel_i[0*CH_W +: CH_W];
  assign tg = texel_i[1*CH_W +: CH_W];
  assign tr = texel_i[2*CH_W +: CH_W];
  assign ta = texel_i[3*CH_W +: CH_W];

  // stage 3: products and bitwise modes
  always_comb begin
    s3_d.is_pixel = s2_i.is_pixel;
    s3_d.in_rect  = s2_i.in_rect;
    s3_d.err      = s2_i.err;
    s3_d.use_mix  = s2_i.in_rect && (mode_i == MODE_ALPHA);
    s3_d.alpha    = s2_i.is_pixel ? s2_i.dest.a : '0;
    s3_d.sum_b    = mix_sum(tb, s2_i.dest.b, ta);
    s3_d.sum_g    = mix_sum(tg, s2_i.dest.g, ta);
    s3_d.sum_r    = mix_sum(tr, s2_i.dest.r, ta);
    s3_d.alt_b    = alt_ch(mode_i, s2_i.in_rect, s2_i.is_pixel, tb, s2_i.dest.b, texel_i);
    s3_d.alt_g    = alt_ch(mode_i, s2_i.in_rect, s2_i.is_pixel, tg, s2_i.dest.g, texel_i);
    s3_d.alt_r    = alt_ch(mode_i, s2_i.in_rect, s2_i.is_pixel, tr, s2_i.dest.r, texel_i);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.s3_en) begin
      s3_q <= s3_d;
    end
  end

  // output stage: rounding divide and final select
  always_comb begin
    rsp_d.out_blue       = s3_q.use_mix ? div255(s3_q.sum_b) : s3_q.alt_b;
    rsp_d.out_green      = s3_q.use_mix ? div255(s3_q.sum_g) : s3_q.alt_g;
    rsp_d.out_red        = s3_q.use_mix ? div255(s3_q.sum_r) : s3_q.alt_r;
    rsp_d.out_alpha      = s3_q.alpha;
    rsp_d.inside_pointer = s3_q.in_rect;
    rsp_d.shape_error    = s3_q.err;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.out_en) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o = rsp_q;

endmodule

[hw/rtl/pointer_overlay_compositor_top.sv]
// ----------------------------------------------------------------------------
// pointer_overlay_compositor_top: hardware cursor overlay compositor
// Loads pointer texels into a shape store and composes frame pixels with it.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+--------------------------
//   in      | sink      | in_valid_i/in_ready_o  | in_req_i   (in_req_t)
//   out     | source    | out_valid_o/out_ready_i| out_rsp_o  (out_rsp_t)
//   cfg     | sink      | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// Throughput is one request per cycle unless the output stalls; every
// request passes four register stages (stage 1 offsets, stage 2 store
// read, stage 3 blend products, output register) before its response is
// valid. The single shape store port pair sets the rate: at most one
// write or one read per request.
// Reset clears valid bits, config registers and the error flag; the shape
// store is not cleared and needs no clearing pass.
// Each stage loads when empty or when the stage after it moves, so bubbles
// collapse and a stalled output keeps the front accepting until full.
//
// Request kinds:
//   load  - texel is written into the store at (row, col) wrapped to the
//           store size; the response carries only the error flag.
//   pixel - composed when inside the pointer rectangle, else passed through.
// Modes: alpha blend with (x+127)/255 rounding, masked color (replace or
// XOR), monochrome (dst AND m) XOR x. In masked mode, a texel alpha other
// than 0 or 255 inside the rectangle raises a sticky error that makes all
// pixels pass unchanged; loading texel (0,0) clears it.
// ----------------------------------------------------------------------------
module pointer_overlay_compositor_top
  import poc_pkg::*;
#(
  parameter int unsigned MAX_POINTER_SIZE = 64,
  parameter int unsigned COORD_BITS       = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  in_req_t                in_req_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output out_rsp_t               out_rsp_o,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned Depth = MAX_POINTER_SIZE * MAX_POINTER_SIZE;
  localparam int unsigned AddrW = $clog2(Depth);

  cfg_t       cfg_q, cfg_d;
  pipe_ctl_t  ctl;
  logic       v1_q, v2_q, v3_q, vout_q;

  logic                ram_we, ram_re;
  logic [AddrW-1:0]    ram_waddr, ram_raddr;
  logic [TEXEL_W-1:0]  ram_wdata, ram_rdata;
  s2_t                 s2;

  // config registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MODE:   cfg_d.mode   = mode_e'(cfg_data_i[1:0]);
        CFG_POS_X:  cfg_d.pos_x  = $signed(cfg_data_i[POS_W-1:0]);
        CFG_POS_Y:  cfg_d.pos_y  = $signed(cfg_data_i[POS_W-1:0]);
        CFG_WIDTH:  cfg_d.width  = cfg_data_i[SIZE_W-1:0];
        CFG_HEIGHT: cfg_d.height = cfg_data_i[SIZE_W-1:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{mode: MODE_ALPHA, pos_x: '0, pos_y: '0,
                 width: SIZE_W'(1), height: SIZE_W'(1)};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // stage enables: a stage loads when it is empty or its successor moves
  always_comb begin
    ctl.out_en = !vout_q || out_ready_i;
    ctl.s3_en  = !v3_q || ctl.out_en;
    ctl.s2_en  = !v2_q || ctl.s3_en;
    ctl.s1_en  = !v1_q || ctl.s2_en;
    ctl.accept = in_valid_i && ctl.s1_en;
    ctl.s1_vld = v1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      vout_q <= 1'b0;
    end else begin
      if (ctl.s1_en)  v1_q   <= in_valid_i;
      if (ctl.s2_en)  v2_q   <= v1_q;
      if (ctl.s3_en)  v3_q   <= v2_q;
      if (ctl.out_en) vout_q <= v3_q;
    end
  end

  assign in_ready_o  = ctl.s1_en;
  assign out_valid_o = vout_q;

  poc_locate #(
    .MAX_POINTER_SIZE (MAX_POINTER_SIZE),
    .COORD_BITS       (COORD_BITS)
  ) u_locate (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .req_i       (in_req_i),
    .cfg_i       (cfg_q),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .s2_o        (s2)
  );

  // shape store, row-major at row * MAX_POINTER_SIZE + col
  poc_ram #(
    .WIDTH (TEXEL_W),
    .DEPTH (Depth)
  ) u_shape_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  poc_compose u_compose (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .mode_i  (cfg_q.mode),
    .s2_i    (s2),
    .texel_i (ram_rdata),
    .rsp_o   (out_rsp_o)
  );

endmodule

[sim/pointer_overlay_compositor_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pointer_overlay_compositor_tb: testbench of the pointer overlay compositor
// Fills part of the store, runs directed cases for each compose mode and the
// corner cases, then random traffic under random valid/ready gaps. Every
// response is checked against an in-bench predictor of the compositor.
// ----------------------------------------------------------------------------
module testbench;
  import poc_pkg::*;

  localparam int          MAX_PTR       = 64;
  // square of the store filled up front; random pointers stay within it
  localparam int          FILL_SIZE     = 32;
  localparam int          PIPE_LAT      = 6;    // pipe depth plus margin
  localparam int          PHASE_ITEMS   = 90;
  localparam longint      TIMEOUT_NS    = 20_000_000;
  // mode 3 is not in mode_e; the block must treat it as pass-through
  localparam logic [1:0]  MODE_RESERVED = 2'd3;

  // --------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  in_req_t               in_req_i    = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_rsp_t              out_rsp_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  always #6 clk_i = ~clk_i;

  pointer_overlay_compositor_top #(
    .MAX_POINTER_SIZE(MAX_PTR),
    .COORD_BITS      (XY_W)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // --------------------------------------------------------------------------
  // Predictor state: mirror of the shape store, sticky alpha error and the
  // pointer registers as last written.
  // --------------------------------------------------------------------------
  logic [TEXEL_W-1:0] shape_mem [MAX_PTR*MAX_PTR];
  bit                 alpha_err = 1'b0;
  logic [1:0]         cur_mode  = MODE_ALPHA;
  int                 cur_x     = 0;
  int                 cur_y     = 0;
  int                 cur_w     = 1;
  int                 cur_h     = 1;

  out_rsp_t composed_q [$];   // responses still owed by the block
  int       mismatch_cnt = 0;
  bit       idle_on      = 1'b1;
  int       hold_cnt     = 0;

  // Gap length for either side: mostly none, some short, a few long.
  function automatic int gap_len();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 20);
  endfunction

  function automatic int sat_size(int v);
    return (v > MAX_PTR) ? MAX_PTR : v;
  endfunction

  // Expected response for one accepted request; updates store and flag.
  function automatic out_rsp_t compose_request(in_req_t req);
    out_rsp_t           rsp;
    logic [TEXEL_W-1:0] tex;
    logic [CH_W-1:0]    dst [3];
    logic [CH_W-1:0]    res [3];
    logic [CH_W-1:0]    and_m, xor_m;
    int                 w, h, dx, dy, alpha, src;
    w   = sat_size(cur_w);
    h   = sat_size(cur_h);
    rsp = '0;
    if (req.req_type == REQ_LOAD) begin
      tex = req.shape_texel;
      shape_mem[int'(req.shape_row) * MAX_PTR + int'(req.shape_col)] = tex;
      // texel (0,0) restarts the shape, so it clears the sticky error first
      if (req.shape_row == 0 && req.shape_col == 0) alpha_err = 1'b0;
      if (cur_mode == MODE_MASKED && int'(req.shape_col) < w && int'(req.shape_row) < h &&
          tex[31:24] != 8'h00 && tex[31:24] != CH_MAX) begin
        alpha_err = 1'b1;
      end
      rsp.shape_error = alpha_err;
      return rsp;
    end
    dst[0] = req.dest_blue;
    dst[1] = req.dest_green;
    dst[2] = req.dest_red;
    res    = dst;
    dx     = int'(req.pixel_x) - cur_x;
    dy     = int'(req.pixel_y) - cur_y;
    if (!alpha_err && cur_mode != MODE_RESERVED && dx >= 0 && dy >= 0 && dx < w && dy < h) begin
      tex   = shape_mem[dy * MAX_PTR + dx];
      alpha = tex[31:24];
      and_m = tex[0] ? CH_MAX : 8'h00;
      xor_m = tex[1] ? CH_MAX : 8'h00;
      rsp.inside_pointer = 1'b1;
      for (int c = 0; c < 3; c++) begin
        src = tex[8*c +: 8];
        case (cur_mode)
          MODE_ALPHA:  res[c] = CH_W'((src * alpha + int'(dst[c]) * (255 - alpha) + 127) / 255);
          MODE_MASKED: res[c] = (alpha == 0) ? src[7:0] : (dst[c] ^ src[7:0]);
          default:     res[c] = (dst[c] & and_m) ^ xor_m;
        endcase
      end
    end
    rsp.out_blue    = res[0];
    rsp.out_green   = res[1];
    rsp.out_red     = res[2];
    rsp.out_alpha   = req.dest_alpha;
    rsp.shape_error = alpha_err;
    return rsp;
  endfunction

  function automatic void report_bad(string what, out_rsp_t want, out_rsp_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $display("%0t: %s exp b=%h g=%h r=%h a=%h in=%b err=%b got b=%h g=%h r=%h a=%h in=%b err=%b",
               $realtime, what, want.out_blue, want.out_green, want.out_red, want.out_alpha,
               want.inside_pointer, want.shape_error, got.out_blue, got.out_green,
               got.out_red, got.out_alpha, got.inside_pointer, got.shape_error);
    end
  endfunction

  function automatic void check_result(out_rsp_t got);
    out_rsp_t want;
    string    bad;
    bad = "";
    if (composed_q.size() == 0) begin
      report_bad("response with no request pending:", '0, got);
      return;
    end
    want = composed_q.pop_front();
    if (got.out_blue       !== want.out_blue)       bad = {bad, " blue"};
    if (got.out_green      !== want.out_green)      bad = {bad, " green"};
    if (got.out_red        !== want.out_red)        bad = {bad, " red"};
    if (got.out_alpha      !== want.out_alpha)      bad = {bad, " alpha"};
    if (got.inside_pointer !== want.inside_pointer) bad = {bad, " inside"};
    if (got.shape_error    !== want.shape_error)    bad = {bad, " error"};
    if (bad != "") report_bad({"field mismatch:", bad, ";"}, want, got);
  endfunction

  // Response side: check on every handshake, then pick ready for next cycle.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) check_result(out_rsp_o);
    if (hold_cnt == 0) hold_cnt = gap_len();
    if (hold_cnt > 0) begin
      out_ready_i <= 1'b0;
      hold_cnt--;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  // Valid is left high after acceptance; the next send either replaces the
  // payload in the same step or lowers valid for a gap.
  task automatic send_item(in_req_t req);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (!in_ready_o);
    composed_q.push_back(compose_request(req));
  endtask

  // Unused fields of a request carry noise; the block must ignore them.
  function automatic in_req_t noise_req();
    logic [127:0] noise;
    noise = {$urandom, $urandom, $urandom, $urandom};
    return noise[$bits(in_req_t)-1:0];
  endfunction

  task automatic send_load(int row, int col, logic [TEXEL_W-1:0] texel);
    in_req_t req;
    req             = noise_req();
    req.req_type    = REQ_LOAD;
    req.shape_row   = row[SHAPE_W-1:0];
    req.shape_col   = col[SHAPE_W-1:0];
    req.shape_texel = texel;
    send_item(req);
  endtask

  // dest is packed B,G,R,A from low byte to high
  task automatic send_pixel(int x, int y, logic [31:0] dest);
    in_req_t req;
    req            = noise_req();
    req.req_type   = REQ_PIXEL;
    req.pixel_x    = x[XY_W-1:0];
    req.pixel_y    = y[XY_W-1:0];
    req.dest_blue  = dest[7:0];
    req.dest_green = dest[15:8];
    req.dest_red   = dest[23:16];
    req.dest_alpha = dest[31:24];
    send_item(req);
  endtask

  // Stop sending and wait until every response is back and the pipe is empty.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (composed_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, int value);
    logic [CFG_DATA_W-1:0] data;
    data = value[CFG_DATA_W-1:0];
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      CFG_MODE:   cur_mode = data[1:0];
      CFG_POS_X:  cur_x    = signed'(data[POS_W-1:0]);
      CFG_POS_Y:  cur_y    = signed'(data[POS_W-1:0]);
      CFG_WIDTH:  cur_w    = data[SIZE_W-1:0];
      CFG_HEIGHT: cur_h    = data[SIZE_W-1:0];
      default: ;
    endcase
  endtask

  // Registers change only with the block idle.
  task automatic set_pointer(logic [1:0] md, int x, int y, int w, int h);
    drain_results();
    write_reg(CFG_MODE, md);
    write_reg(CFG_POS_X, x);
    write_reg(CFG_POS_Y, y);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
  endtask

  // Texel with alpha biased to 0 and 255; clean_alpha forbids other values.
  function automatic logic [TEXEL_W-1:0] rand_texel(bit clean_alpha);
    logic [TEXEL_W-1:0] t;
    t = $urandom;
    case ($urandom_range(0, 3))
      0: t[31:24] = 8'h00;
      1: t[31:24] = CH_MAX;
      default: if (clean_alpha) t[31:24] = $urandom_range(0, 1) ? CH_MAX : 8'h00;
    endcase
    return t;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Writes the top-left FILL_SIZE square; later reads stay inside it or hit
  // texels that the test loads first.
  task automatic test_shape_fill();
    set_pointer(MODE_ALPHA, 0, 0, MAX_PTR, MAX_PTR);
    for (int row = 0; row < FILL_SIZE; row++) begin
      for (int col = 0; col < FILL_SIZE; col++) send_load(row, col, rand_texel(1'b0));
    end
  endtask

  task automatic test_alpha_blend();
    set_pointer(MODE_ALPHA, 100, 200, 8, 8);
    send_load(0, 0, 32'h00_102030);          // transparent
    send_load(0, 1, 32'hFF_405060);          // opaque
    send_load(1, 0, 32'h80_FF00FF);          // half
    send_pixel(100, 200, 32'hAA_FFFFFF);
    send_pixel(101, 200, 32'h00_000000);
    send_pixel(100, 201, 32'h55_00FF00);
    send_pixel(99, 200, 32'h12_345678);      // left of pointer
    send_pixel(108, 207, 32'hFF_FFFFFF);     // one past the right edge
  endtask

  task automatic test_masked_color();
    set_pointer(MODE_MASKED, 0, 0, 4, 4);
    send_load(0, 0, 32'h00_123456);          // replace
    send_load(0, 1, 32'hFF_0F0F0F);          // invert
    send_pixel(0, 0, 32'h77_ABCDEF);
    send_pixel(1, 0, 32'h77_ABCDEF);
    send_load(3, 5, 32'h40_000000);          // bad alpha outside the rectangle
    send_load(2, 2, 32'h7F_111111);          // bad alpha inside: error sets
    send_pixel(0, 0, 32'h01_FEDCBA);         // passes while error is held
    send_load(0, 0, 32'h00_654321);          // origin load clears the error
    send_pixel(0, 0, 32'h02_FEDCBA);
  endtask

  task automatic test_monochrome();
    // pointer at the far frame corner, texel low bits cover all AND/XOR pairs
    set_pointer(MODE_MONO, 4092, 4095, MAX_PTR, MAX_PTR);
    for (int col = 0; col < 4; col++) send_load(0, col, {$urandom} & ~32'h3 | col);
    for (int col = 0; col < 4; col++) send_pixel(4092 + col, 4095, 32'hC3_F00F5A);
  endtask

  task automatic test_position_extremes();
    set_pointer(MODE_ALPHA, -4096, -4096, MAX_PTR, MAX_PTR);
    send_pixel(0, 0, 32'h00_000000);
    send_pixel(4095, 4095, 32'hFF_FFFFFF);
    set_pointer(MODE_ALPHA, -63, -1, MAX_PTR, MAX_PTR);
    send_load(1, MAX_PTR - 1, 32'h80_336699);
    send_pixel(0, 0, 32'h5A_A5A5A5);         // last column, second row
    set_pointer(MODE_MASKED, 4095, 4095, 1, 1);
    send_pixel(4095, 4095, 32'h3C_C3C3C3);
    send_pixel(4094, 4095, 32'h3C_C3C3C3);
  endtask

  task automatic test_reserved_and_sizes();
    set_pointer(MODE_RESERVED, 0, 0, MAX_PTR, MAX_PTR);
    send_pixel(5, 5, 32'h11_223344);
    set_pointer(MODE_MONO, 0, 0, 0, 10);     // zero width: empty rectangle
    send_pixel(0, 0, 32'h11_223344);
    set_pointer(MODE_ALPHA, 0, 0, 127, 100); // both sizes clip to the store
    send_load(MAX_PTR - 1, MAX_PTR - 1, 32'h40_C0FFEE);
    send_pixel(63, 63, 32'h99_887766);
    send_pixel(64, 0, 32'h99_887766);
    send_pixel(0, 64, 32'h99_887766);
  endtask

  // Phases of mixed loads and pixels aimed at and around the pointer.
  task automatic test_random_traffic();
    logic [1:0] md;
    int         px, py, w, h, r;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 3)
        0:       md = MODE_ALPHA;
        1:       md = MODE_MASKED;
        default: md = MODE_MONO;
      endcase
      case ($urandom_range(0, 3))
        0:       begin px = $urandom_range(0, 63); px = -px; end
        1:       px = 4095 - int'($urandom_range(0, 63));
        default: px = $urandom_range(0, 4000);
      endcase
      case ($urandom_range(0, 3))
        0:       begin py = $urandom_range(0, 63); py = -py; end
        1:       py = 4095 - int'($urandom_range(0, 63));
        default: py = $urandom_range(0, 4000);
      endcase
      w = (ph == 0) ? 1 : (ph == 1) ? FILL_SIZE : $urandom_range(2, FILL_SIZE);
      h = (ph == 0) ? FILL_SIZE : (ph == 1) ? 1 : $urandom_range(2, FILL_SIZE);
      set_pointer(md, px, py, w, h);
      idle_on = (ph % 4 != 3);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 4 && i == PHASE_ITEMS / 2) drain_results();
        if ($urandom_range(0, 99) < 30) begin
          if ($urandom_range(0, 19) == 0) begin
            send_load(0, 0, rand_texel(1'b1));
          end else if ($urandom_range(0, 99) < 80) begin
            // masked mode: a rare bad alpha, so the error sets now and then
            send_load($urandom_range(0, h - 1), $urandom_range(0, w - 1),
                      rand_texel(md == MODE_MASKED && $urandom_range(0, 39) != 0));
          end else begin
            send_load($urandom_range(0, 63), $urandom_range(0, 63), rand_texel(1'b0));
          end
        end else begin
          if ($urandom_range(0, 99) < 80) begin
            r = $urandom_range(0, w + 7);
            px = cur_x + r - 4;
            r = $urandom_range(0, h + 7);
            py = cur_y + r - 4;
            if (px < 0 || px > 4095) px = $urandom_range(0, 4095);
            if (py < 0 || py > 4095) py = $urandom_range(0, 4095);
          end else begin
            px = $urandom_range(0, 4095);
            py = $urandom_range(0, 4095);
          end
          send_pixel(px, py, $urandom);
        end
      end
    end
    idle_on = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_shape_fill();
    test_alpha_blend();
    test_masked_color();
    test_monochrome();
    test_position_extremes();
    test_reserved_and_sizes();
    test_random_traffic();
    drain_results();
    repeat (PIPE_LAT) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("pointer_overlay_compositor_top: match");
    end else begin
      $display("pointer_overlay_compositor_top: mismatch");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #(TIMEOUT_NS);
    $display("pointer_overlay_compositor_top: mismatch");
    $finish;
  end

endmodule
